/* rtl/bfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_pkg
// Types, constants and codes shared by the bit field packer/unpacker modules.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int STORE_BYTES    = 1024;
  localparam int MAX_FIELD_BITS = 32;

  localparam int WINDOW_BITS = MAX_FIELD_BITS + 8;
  localparam int SLOTS       = WINDOW_BITS / 8;
  localparam int SLOT_W      = $clog2(SLOTS + 1);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int BW          = $clog2(STORE_BYTES + 1);
  localparam int CW          = $clog2(STORE_BYTES * 8 + 1);
  localparam int NW          = $clog2(MAX_FIELD_BITS + 1);
  localparam int RSW         = $clog2(WINDOW_BITS);

  // fixed field widths of the transactions
  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 6;
  localparam int POS_W   = 14;
  localparam int STAT_W  = 2;
  localparam int SIZE_W  = 11;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 64;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(896);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_FIELD = 3'd0,
    CMD_READ_FIELD  = 3'd1,
    CMD_WRITE_FLAG  = 3'd2,
    CMD_READ_FLAG   = 3'd3,
    CMD_SET_CURSOR  = 3'd4,
    CMD_OPEN        = 3'd5,
    CMD_CLOSE       = 3'd6,
    CMD_CLEAR       = 3'd7
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_WR_PAST  = 2'd1,
    STAT_RD_PAST  = 2'd2,
    STAT_ROLLBACK = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic rd_issue;
    logic clr_write;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic mem_op;
    logic is_clear;
    logic clr_empty;
    logic last_issue;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/bit_field_packer_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_field_packer_unpacker
// MSB-first bit field packer/unpacker over a 1024-byte store.
// ----------------------------------------------------------------------------
// usage
//   slave channel takes one command per transaction: tuser carries the command,
//   tdata the write value, bit count, sign-extend flag and new cursor
//   master channel returns one result transaction per command: read value,
//   status, cursor, bits used and the sticky overwrite flag
//   cfg_wen_i/cfg_wdata_i write the store size in bytes, only while idle
// timing
//   one command at a time; a field access read-modify-writes one byte per
//   cycle through the single store port, over every byte the field spans,
//   and then drains the last access; clear zeroes the store byte by byte up
//   to the size in bytes
// reset
//   after reset a clearing pass zeroes all 1024 store bytes; tready stays
//   low until it ends; cursor, bits used and flags reset to zero, size to 896
// stall
//   the result register holds a finished transaction while tready is low;
//   the next command is accepted, and its result waits until the slot frees
// ----------------------------------------------------------------------------
module bit_field_packer_unpacker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wen_i,
  input  logic [bfp_pkg::SIZE_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // write_value[31:0], bit_count[37:32], sign_extend[38], new_cursor[52:39]
  input  logic [bfp_pkg::IN_W-1:0]   s_axis_tdata,
  // command[2:0]
  input  logic [bfp_pkg::CMD_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // read_value[31:0], status[33:32], cursor[47:34], bits_used[61:48],
  // overwrite[62]
  output logic [bfp_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bfp_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  bfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:34] <= 14'd8192))
    else $error("cursor beyond store");

  a_read_past_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:32] == STAT_RD_PAST)) |->
      (m_axis_tdata[31:0] == '0))
    else $error("read past end returned data");

  a_rollback_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:32] == STAT_ROLLBACK)) |-> !m_axis_tdata[62])
    else $error("rollback left overwrite set");

endmodule

/* rtl/bfp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_ctrl
// Sequencer: clearing pass, decode, byte-wise store access and result hand-off.
// ----------------------------------------------------------------------------
module bfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output bfp_pkg::dp_cmd_t  cmd_o,
  input  bfp_pkg::dp_stat_t stat_i
);
  import bfp_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EVAL   = 7'b0000100,
    ST_ACCESS = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_CLEAR  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.mem_op) begin
          state_d = ST_ACCESS;
        end else if (stat_i.is_clear && !stat_i.clr_empty) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_ACCESS: begin
        cmd_o.rd_issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

/* rtl/bfp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfp_dp
// Datapath: byte store, cursor state, bit window build and result register.
// ----------------------------------------------------------------------------
module bfp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfp_pkg::dp_cmd_t              cmd_i,
  output bfp_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_wen_i,
  input  logic [bfp_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic [bfp_pkg::IN_W-1:0]      in_data_i,
  input  logic [bfp_pkg::CMD_W-1:0]     in_cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bfp_pkg::OUT_W-1:0]     out_data_o
);
  import bfp_pkg::*;

  localparam logic [WINDOW_BITS-1:0] ALL_ONES = {WINDOW_BITS{1'b1}};
  localparam logic [CW-1:0] MAX_CURSOR = CW'(STORE_BYTES * 8);

  function automatic logic [7:0] slot_byte(logic [WINDOW_BITS-1:0] w,
                                           logic [SLOT_W-1:0] k);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (SLOT_W'(j) == k) begin
        r = w[WINDOW_BITS-1-8*j -: 8];
      end
    end
    return r;
  endfunction

  // input fields
  logic [VAL_W-1:0] in_wv;
  logic [CNT_W-1:0] in_cnt;
  logic             in_sx;
  logic [POS_W-1:0] in_nc;
  cmd_e             in_cmd;

  assign in_wv  = in_data_i[31:0];
  assign in_cnt = in_data_i[37:32];
  assign in_sx  = in_data_i[38];
  assign in_nc  = in_data_i[52:39];
  assign in_cmd = cmd_e'(in_cmd_i);

  // latched transaction
  cmd_e             cmd_q;
  logic [VAL_W-1:0] wv_q;
  logic [NW-1:0]    n_q;
  logic             sx_q;
  logic [POS_W-1:0] nc_q;

  logic [SIZE_W-1:0] size_q;

  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] mark_q, mark_d;
  logic          ovf_q, ovf_d;
  logic          open_q, open_d;
  status_e       stat_q, stat_d;
  logic          rd_ok_q, rd_ok_d;
  logic          wr_ok_q, wr_ok_d;

  // window of the current access
  logic [AW-1:0]          first_q;
  logic [SLOT_W-1:0]      nbytes_q;
  logic [RSW-1:0]         rs_q;
  logic [WINDOW_BITS-1:0] wmask_q;
  logic [WINDOW_BITS-1:0] wdata_q;
  logic [WINDOW_BITS-1:0] acc_q;
  logic [SLOT_W-1:0]      idx_q;
  logic                   pend_q;
  logic [SLOT_W-1:0]      pend_slot_q;
  logic [AW-1:0]          pend_addr_q;

  // clearing sweep
  logic [AW-1:0] clr_addr_q;
  logic [BW-1:0] clr_end_q;

  // store
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [AW-1:0] rd_addr;

  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;

  // decode helpers
  logic [BW-1:0]          lim_bytes;
  logic [CW-1:0]          limit;
  logic                   fits;
  logic [CW-1:0]          new_cur;
  logic [2:0]             off;
  logic [RSW-1:0]         rs;
  logic [WINDOW_BITS-1:0] wmask;
  logic [NW:0]            span;
  logic [NW-1:0]          n_in;

  always_comb begin
    if (in_cnt == '0) begin
      n_in = NW'(1);
    end else if (32'(in_cnt) > 32'(MAX_FIELD_BITS)) begin
      n_in = NW'(MAX_FIELD_BITS);
    end else begin
      n_in = NW'(in_cnt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd;
      nc_q  <= in_nc;
      sx_q  <= in_sx & (in_cmd == CMD_READ_FIELD);
      if (in_cmd == CMD_WRITE_FLAG || in_cmd == CMD_READ_FLAG) begin
        n_q  <= NW'(1);
        wv_q <= {{(VAL_W-1){1'b0}}, in_wv[0]};
      end else begin
        n_q  <= n_in;
        wv_q <= in_wv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_wen_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign lim_bytes = (32'(size_q) > 32'(STORE_BYTES)) ? BW'(STORE_BYTES) : BW'(size_q);
  assign limit     = CW'({lim_bytes, 3'b000});
  assign fits      = ({1'b0, cursor_q} + (CW+1)'(n_q)) <= {1'b0, limit};
  assign new_cur   = cursor_q + CW'(n_q);
  assign off       = cursor_q[2:0];
  assign rs        = RSW'(WINDOW_BITS) - RSW'(off) - RSW'(n_q);
  assign wmask     = (ALL_ONES >> off) & (ALL_ONES << rs);
  assign span      = (NW+1)'(off) + (NW+1)'(n_q) - (NW+1)'(1);

  always_comb begin
    cursor_d = cursor_q;
    used_d   = used_q;
    mark_d   = mark_q;
    ovf_d    = ovf_q;
    open_d   = open_q;
    stat_d   = stat_q;
    rd_ok_d  = rd_ok_q;
    wr_ok_d  = wr_ok_q;
    if (cmd_i.eval) begin
      stat_d  = STAT_OK;
      rd_ok_d = 1'b0;
      wr_ok_d = 1'b0;
      case (cmd_q)
        CMD_WRITE_FIELD, CMD_WRITE_FLAG: begin
          if (fits) begin
            wr_ok_d  = 1'b1;
            cursor_d = new_cur;
            if (new_cur > used_q) begin
              used_d = new_cur;
            end
          end else begin
            stat_d = STAT_WR_PAST;
            if (cmd_q == CMD_WRITE_FIELD || wv_q[0]) begin
              ovf_d = 1'b1;
            end
          end
        end
        CMD_READ_FIELD, CMD_READ_FLAG: begin
          if (fits) begin
            rd_ok_d  = 1'b1;
            cursor_d = new_cur;
          end else begin
            stat_d = STAT_RD_PAST;
          end
        end
        CMD_SET_CURSOR: begin
          cursor_d = (32'(nc_q) > 32'(MAX_CURSOR)) ? MAX_CURSOR : CW'(nc_q);
        end
        CMD_OPEN: begin
          mark_d = cursor_q;
          open_d = 1'b1;
        end
        CMD_CLOSE: begin
          if (open_q) begin
            if (ovf_q) begin
              cursor_d = mark_q;
              ovf_d    = 1'b0;
              stat_d   = STAT_ROLLBACK;
            end
            open_d = 1'b0;
          end
        end
        CMD_CLEAR: begin
          cursor_d = '0;
          used_d   = '0;
        end
        default: begin
          stat_d = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      used_q   <= '0;
      mark_q   <= '0;
      ovf_q    <= 1'b0;
      open_q   <= 1'b0;
      stat_q   <= STAT_OK;
      rd_ok_q  <= 1'b0;
      wr_ok_q  <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      used_q   <= used_d;
      mark_q   <= mark_d;
      ovf_q    <= ovf_d;
      open_q   <= open_d;
      stat_q   <= stat_d;
      rd_ok_q  <= rd_ok_d;
      wr_ok_q  <= wr_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      first_q  <= AW'(cursor_q >> 3);
      nbytes_q <= SLOT_W'(span >> 3) + SLOT_W'(1);
      rs_q     <= rs;
      wmask_q  <= wmask;
      wdata_q  <= (WINDOW_BITS'(wv_q) << rs) & wmask;
    end
    if (cmd_i.eval) begin
      acc_q <= '0;
    end else if (pend_q && rd_ok_q) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (SLOT_W'(j) == pend_slot_q) begin
          acc_q[WINDOW_BITS-1-8*j -: 8] <= mem_rdata_q;
        end
      end
    end
    pend_slot_q <= idx_q;
    pend_addr_q <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      pend_q     <= 1'b0;
      clr_addr_q <= '0;
      clr_end_q  <= BW'(STORE_BYTES);
    end else begin
      pend_q <= cmd_i.rd_issue;
      if (cmd_i.eval) begin
        idx_q <= '0;
      end else if (cmd_i.rd_issue) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (cmd_i.eval) begin
        clr_addr_q <= '0;
        clr_end_q  <= lim_bytes;
      end else if (cmd_i.clr_write) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  assign rd_addr = first_q + AW'(idx_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pend_addr_q;
    mem_wd = (mem_rdata_q & ~slot_byte(wmask_q, pend_slot_q)) | slot_byte(wdata_q, pend_slot_q);
    if (cmd_i.clr_write) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if (pend_q && wr_ok_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= mem[rd_addr];
  end

  // field extraction for reads
  logic [WINDOW_BITS-1:0] raw;
  logic [VAL_W-1:0]       rv_field;
  logic [VAL_W-1:0]       rv;
  logic                   sign_bit;

  assign raw      = (acc_q & wmask_q) >> rs_q;
  assign rv_field = VAL_W'(raw);
  assign sign_bit = rv_field[5'(n_q - NW'(1))];

  always_comb begin
    rv = '0;
    if (rd_ok_q) begin
      rv = rv_field;
      if (sx_q && (32'(n_q) < VAL_W) && sign_bit) begin
        rv = rv_field | ({VAL_W{1'b1}} << n_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {1'b0, ovf_q, POS_W'(used_q), POS_W'(cursor_q), stat_q, rv};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.mem_op     = wr_ok_d | rd_ok_d;
  assign stat_o.is_clear   = (cmd_q == CMD_CLEAR);
  assign stat_o.clr_empty  = (lim_bytes == '0);
  assign stat_o.last_issue = (idx_q == nbytes_q - SLOT_W'(1));
  assign stat_o.clr_last   = ((BW'(clr_addr_q) + BW'(1)) == clr_end_q);
  assign stat_o.out_busy   = out_valid_q & ~out_ready_i;

endmodule

/* test/tb_bit_field_packer_unpacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_field_packer_unpacker
// Streams commands into the packer and checks every result against a
// bit-level model of the store, cursor, section mark and overwrite flag.
// A directed opener hits field widths, offsets, past-end and section cases;
// random framed write/read-back sections with noise follow over many store
// sizes, with idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
import bfp_pkg::*;

typedef struct packed {
  logic [31:0] read_value;
  status_e     status;
  logic [13:0] cursor;
  logic [13:0] bits_used;
  logic        overwrite;
} packer_result_t;

class packer_scoreboard;
  logic [7:0]     mem_bytes [STORE_BYTES];
  int unsigned    cur;
  int unsigned    used;
  logic           ovf;
  int unsigned    mark;
  logic           sec_open;
  int unsigned    size_bytes;
  packer_result_t expected_results [$];
  int             mismatches;
  int             refused_writes;
  int             past_reads;
  int             rollbacks;

  function new();
    foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
    cur = 0;
    used = 0;
    ovf = 1'b0;
    mark = 0;
    sec_open = 1'b0;
    size_bytes = 896;
    mismatches = 0;
    refused_writes = 0;
    past_reads = 0;
    rollbacks = 0;
  endfunction

  // msb-first: stream bit p is bit 7 - p%8 of byte p/8
  function void put_bits(logic [31:0] value, int unsigned n);
    int unsigned p;
    for (int unsigned k = 0; k < n; k++) begin
      p = cur + k;
      mem_bytes[p >> 3][7 - (p & 7)] = value[n - 1 - k];
    end
  endfunction

  function logic [31:0] get_bits(int unsigned n);
    logic [31:0] v;
    int unsigned p;
    v = '0;
    for (int unsigned k = 0; k < n; k++) begin
      p = cur + k;
      v = {v[30:0], mem_bytes[p >> 3][7 - (p & 7)]};
    end
    return v;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void note_command(cmd_e cmd, logic [31:0] wv, logic [5:0] bc, logic sx,
                             logic [13:0] nc);
    int unsigned    limit;
    int unsigned    n;
    packer_result_t r;
    limit = 8 * ((size_bytes > STORE_BYTES) ? STORE_BYTES : size_bytes);
    n = (bc == 0) ? 1 : ((bc > MAX_FIELD_BITS) ? MAX_FIELD_BITS : bc);
    r.read_value = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_WRITE_FIELD: begin
        if (cur + n > limit) begin
          ovf = 1'b1;
          r.status = STAT_WR_PAST;
        end else begin
          put_bits(wv, n);
          cur += n;
          if (cur > used) used = cur;
        end
      end
      CMD_READ_FIELD: begin
        if (cur + n > limit) begin
          r.status = STAT_RD_PAST;
        end else begin
          r.read_value = get_bits(n);
          cur += n;
          if (sx && n < 32 && r.read_value[n - 1])
            r.read_value = r.read_value | (32'hFFFF_FFFF << n);
        end
      end
      CMD_WRITE_FLAG: begin
        if (cur >= limit) begin
          if (wv[0]) ovf = 1'b1;
          r.status = STAT_WR_PAST;
        end else begin
          put_bits({31'b0, wv[0]}, 1);
          cur += 1;
          if (cur > used) used = cur;
        end
      end
      CMD_READ_FLAG: begin
        if (cur >= limit) begin
          r.status = STAT_RD_PAST;
        end else begin
          r.read_value = get_bits(1);
          cur += 1;
        end
      end
      CMD_SET_CURSOR: begin
        cur = (nc > STORE_BYTES * 8) ? STORE_BYTES * 8 : nc;
      end
      CMD_OPEN: begin
        mark = cur;
        sec_open = 1'b1;
      end
      CMD_CLOSE: begin
        if (sec_open) begin
          if (ovf) begin
            cur = mark;
            ovf = 1'b0;
            r.status = STAT_ROLLBACK;
          end
          sec_open = 1'b0;
        end
      end
      default: begin
        for (int unsigned i = 0; i < limit / 8; i++) mem_bytes[i] = 8'h00;
        cur = 0;
        used = 0;
      end
    endcase
    if (r.status == STAT_WR_PAST) refused_writes++;
    if (r.status == STAT_RD_PAST) past_reads++;
    if (r.status == STAT_ROLLBACK) rollbacks++;
    r.cursor = cur[13:0];
    r.bits_used = used[13:0];
    r.overwrite = ovf;
    expected_results.push_back(r);
  endfunction

  function void check_result(logic [OUT_W-1:0] d);
    packer_result_t e;
    if (expected_results.size() == 0) begin
      $error("result transaction with no command pending: %h", d);
      mismatches++;
      return;
    end
    e = expected_results.pop_front();
    if (d[31:0] !== e.read_value) begin
      $error("read_value: expected %h, actual %h", e.read_value, d[31:0]);
      mismatches++;
    end
    if (d[33:32] !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, d[33:32]);
      mismatches++;
    end
    if (d[47:34] !== e.cursor) begin
      $error("cursor: expected %0d, actual %0d", e.cursor, d[47:34]);
      mismatches++;
    end
    if (d[61:48] !== e.bits_used) begin
      $error("bits_used: expected %0d, actual %0d", e.bits_used, d[61:48]);
      mismatches++;
    end
    if (d[62] !== e.overwrite) begin
      $error("overwrite: expected %0d, actual %0d", e.overwrite, d[62]);
      mismatches++;
    end
  endfunction
endclass

module tb_bit_field_packer_unpacker;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 135;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wen_i;
  logic [SIZE_W-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic [CMD_W-1:0]  s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  packer_scoreboard sb;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          commands_sent;
  int          size_settings;
  int unsigned cur_size;
  int          cycle_count = 0;

  bit_field_packer_unpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check on each accepted transaction, then pick the next tready
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic int unsigned limit_bits();
    return 8 * ((cur_size > STORE_BYTES) ? STORE_BYTES : cur_size);
  endfunction

  task automatic send_command(input cmd_e cmd, input logic [31:0] wv, input logic [5:0] bc,
                              input logic sx, input logic [13:0] nc);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, nc, sx, bc, wv};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(cmd, wv, bc, sx, nc);
    commands_sent++;
  endtask

  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_size(input int unsigned v);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= v[SIZE_W-1:0];
    @(posedge clk_i);
    cfg_wen_i   <= 1'b0;
    sb.size_bytes = v;
    cur_size = v;
    size_settings++;
  endtask

  // optionally clear, then open a section at a random cursor, write fields and flags, close, then read them back
  task automatic run_section_sequence();
    int unsigned count;
    int unsigned start;
    int unsigned lim;
    logic [5:0]  widths [6];
    logic        flag_item [6];
    lim = limit_bits();
    count = $urandom_range(6, 1);
    for (int k = 0; k < count; k++) begin
      flag_item[k] = ($urandom_range(99) < 20);
      widths[k] = ($urandom_range(99) < 10) ? 6'($urandom_range(63)) : 6'($urandom_range(32, 1));
    end
    if ($urandom_range(99) < 8)
      send_command(CMD_CLEAR, $urandom, 6'($urandom), 1'($urandom), 14'($urandom));
    if (lim == 0) start = 0;
    else if ($urandom_range(99) < 60) start = $urandom_range(lim);
    else start = lim - $urandom_range((lim < 48) ? lim : 48);
    send_command(CMD_SET_CURSOR, $urandom, 6'($urandom), 1'($urandom), 14'(start));
    send_command(CMD_OPEN, $urandom, 6'($urandom), 1'($urandom), 14'($urandom));
    for (int k = 0; k < count; k++) begin
      if (flag_item[k])
        send_command(CMD_WRITE_FLAG, $urandom, 6'($urandom), 1'($urandom), 14'($urandom));
      else
        send_command(CMD_WRITE_FIELD, $urandom, widths[k], 1'($urandom), 14'($urandom));
    end
    send_command(CMD_CLOSE, $urandom, 6'($urandom), 1'($urandom), 14'($urandom));
    send_command(CMD_SET_CURSOR, $urandom, 6'($urandom), 1'($urandom), 14'(start));
    for (int k = 0; k < count; k++) begin
      if (flag_item[k])
        send_command(CMD_READ_FLAG, $urandom, 6'($urandom), 1'($urandom), 14'($urandom));
      else
        send_command(CMD_READ_FIELD, $urandom, widths[k], 1'($urandom), 14'($urandom));
    end
  endtask

  task automatic send_noise_command();
    cmd_e        cmd;
    logic [13:0] nc;
    cmd = cmd_e'($urandom_range(7));
    if (cmd == CMD_CLEAR && $urandom_range(99) < 85) cmd = CMD_READ_FIELD;
    nc = $urandom_range(1) ? 14'($urandom_range(16383)) : 14'($urandom_range(limit_bits()));
    send_command(cmd, $urandom, 6'($urandom_range(63)), 1'($urandom), nc);
  endtask

  initial begin
    int          sender_modes [4];
    int          receiver_modes [4];
    int unsigned phase_sizes [12];
    int          phase_end;
    sender_modes   = '{0, 85, 0, 29};
    receiver_modes = '{0, 0, 85, 29};
    phase_sizes    = '{896, 1, 1024, 0, 8, 2047, 3, 16, 2, 64, 5, 1023};
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    commands_sent = 0;
    size_settings = 0;
    cur_size = 896;
    rst_ni        <= 1'b0;
    cfg_wen_i     <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: offsets, width clamping, sign extension, past end, sections
    write_size(896);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd3);
    send_command(CMD_WRITE_FIELD, 32'hA5C3_0F81, 6'd32, 1'b0, 14'd0);
    send_command(CMD_WRITE_FIELD, 32'h0000_0001, 6'd0, 1'b0, 14'd0);
    send_command(CMD_WRITE_FIELD, 32'hFFFF_FFFF, 6'd63, 1'b0, 14'd0);
    send_command(CMD_WRITE_FLAG, 32'hFFFF_FFFE, 6'd0, 1'b0, 14'd0);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd3);
    send_command(CMD_READ_FIELD, 32'h0, 6'd5, 1'b1, 14'd0);
    send_command(CMD_READ_FIELD, 32'h0, 6'd63, 1'b0, 14'd0);
    send_command(CMD_READ_FIELD, 32'h0, 6'd0, 1'b1, 14'd0);
    send_command(CMD_READ_FLAG, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'h3FFF);
    send_command(CMD_CLOSE, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_WRITE_FLAG, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_READ_FIELD, 32'h0, 6'd32, 1'b1, 14'd0);
    send_command(CMD_READ_FLAG, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd100);
    send_command(CMD_OPEN, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_WRITE_FLAG, 32'h1, 6'd0, 1'b0, 14'd0);
    send_command(CMD_OPEN, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd8192);
    send_command(CMD_WRITE_FIELD, 32'h0000_00FF, 6'd8, 1'b0, 14'd0);
    send_command(CMD_CLOSE, 32'h0, 6'd0, 1'b0, 14'd0);
    send_command(CMD_CLEAR, 32'h0, 6'd0, 1'b0, 14'd0);
    wait_until_idle();
    write_size(1);
    send_command(CMD_WRITE_FIELD, 32'h0000_00C3, 6'd8, 1'b0, 14'd0);
    send_command(CMD_WRITE_FLAG, 32'h1, 6'd0, 1'b0, 14'd0);
    wait_until_idle();
    write_size(2047);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd8160);
    send_command(CMD_WRITE_FIELD, 32'h8123_4567, 6'd32, 1'b0, 14'd0);
    send_command(CMD_SET_CURSOR, 32'h0, 6'd0, 1'b0, 14'd8160);
    send_command(CMD_READ_FIELD, 32'h0, 6'd32, 1'b1, 14'd0);

    for (int ph = 0; ph < 12; ph++) begin
      wait_until_idle();
      write_size(phase_sizes[ph]);
      sender_idle_pct = sender_modes[ph % 4];
      receiver_stall_pct = receiver_modes[ph % 4];
      phase_end = commands_sent + ITEMS_PER_PHASE;
      while (commands_sent < phase_end) begin
        if ($urandom_range(99) < 75) run_section_sequence();
        else repeat ($urandom_range(4, 1)) send_noise_command();
      end
    end

    wait_until_idle();
    $display("covered %0d commands over %0d store size settings and four idle/stall mixes",
             commands_sent, size_settings);
    $display("%0d refused writes, %0d reads past the end, %0d section rollbacks",
             sb.refused_writes, sb.past_reads, sb.rollbacks);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
